### src/sc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc_pkg: shared types and constants of the stereo crush effect
// Word formats, register indexes, mode codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sc_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = SAMPLE_BITS - 1;
  localparam int MAX_LEVEL_DEF = 6;
  localparam int MODE_W        = 2;
  localparam int LEVEL_W       = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 1'b1;

  // mode codes; the unused code behaves as the sign mode
  localparam logic [MODE_W-1:0] MODE_AVG   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QUANT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIGN  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          end_of_call;
  } sc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          last_of_run;
  } sc_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_SETUP,
    S_DIV,
    S_EMIT
  } sc_state_e;

  typedef struct packed {
    logic latch;      // capture the input word
    logic acc;        // add into the window, or form the quantizer product
    logic start_div;  // launch both divider lanes, close the window
    logic load_sign;  // load sign results, close the window
    logic load_zero;  // load zero results
    logic take_div;   // load the signed quotients
    logic pop;        // one result word taken
  } sc_cmd_t;

  typedef struct packed {
    logic quant;
    logic sign_mode;
    logic close;
    logic lvl_zero;
    logic div_done;
    logic last;
  } sc_sts_t;

endpackage

### src/stereo_crush_effect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_crush_effect: stereo sample-rate and bit-depth crusher
// Window average, window sign clip and bit-depth quantize on Q1.15 pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (left, right, end_of_call) arrive on in_valid_i/in_ready_o;
//   result words leave on out_valid_o/out_ready_i. Mode and level are set
//   through the write port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while idle;
//   the user must keep to this, as the block does not enforce it. The block
//   holds one input word at a time: in_ready_o is high only when every
//   result word of the previous input has been taken. A window-mode input
//   that does not close its window returns ready in idle after accumulate
//   and setup. A closing average window or a quantized pair above level
//   zero goes through a bit-serial divider, one quotient bit per cycle, and
//   its first result word is valid once the quotients are loaded; a
//   sign-mode close or a level-zero quantize goes from setup to emit.
//   A closing window then emits one word per pair in the window, back to
//   back, with last_of_run set on the final one; quantize emits one word.
//   When the receiver stalls, the result register holds its word and the
//   block waits; nothing is dropped.
//   Reset clears mode, level, window sums and count, and leaves the block
//   idle and ready; no clearing pass is needed.
// ----------------------------------------------------------------------------
module stereo_crush_effect
  import sc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sc_in_t                in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sc_out_t               out_data_o
);

  sc_cmd_t cmd;
  sc_sts_t sts;

  // sequence each word: accumulate, set up, divide, emit
  sc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // hold config, window state, divider lanes and the result word
  sc_dp #(.MAX_LEVEL(MAX_LEVEL)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_data_i,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o
  );

endmodule

### src/sc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc_div: serial unsigned divider lane
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sc_div
  import sc_pkg::*;
#(
  parameter int DVD_W = SAMPLE_BITS + MAX_LEVEL_DEF,
  parameter int DVS_W = MAX_LEVEL_DEF + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quot_o,
  output logic             done_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // shift the quotient bit in where the dividend bit leaves
      dvd_d  = {dvd_q[DVD_W-2:0], fits};
      rem_d  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quot_o = dvd_q;
  assign done_o = !busy_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_nonzero_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("divider started with zero divisor");

endmodule

### src/sc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc_ctrl: sequencing controller
// Walks one input word through accumulate, setup, divide and emit.
// ----------------------------------------------------------------------------
module sc_ctrl
  import sc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  sc_sts_t sts_i,
  output sc_cmd_t cmd_o
);

  sc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ACC;
      S_ACC:   state_d = S_SETUP;
      S_SETUP: begin
        if (sts_i.quant) begin
          state_d = sts_i.lvl_zero ? S_EMIT : S_DIV;
        end else if (sts_i.close) begin
          state_d = sts_i.sign_mode ? S_EMIT : S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV:   if (sts_i.div_done) state_d = S_EMIT;
      S_EMIT:  if (out_ready_i && sts_i.last) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_ACC:  cmd_o.acc = 1'b1;
      S_SETUP: begin
        if (sts_i.quant) begin
          cmd_o.load_zero = sts_i.lvl_zero;
          cmd_o.start_div = !sts_i.lvl_zero;
        end else if (sts_i.close) begin
          cmd_o.load_sign = sts_i.sign_mode;
          cmd_o.start_div = !sts_i.sign_mode;
        end
      end
      S_DIV:  cmd_o.take_div = sts_i.div_done;
      S_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open at once");

  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> $past(state_q) == S_SETUP || $past(state_q) == S_DIV)
    else $error("divide entered without setup");

endmodule

### src/sc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sc_dp: crush datapath
// Configuration registers, window sums, quantizer product, two divider
// lanes, result registers and the count of result words still owed.
// ----------------------------------------------------------------------------
module sc_dp
  import sc_pkg::*;
#(
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  sc_in_t                in_data_i,
  input  sc_cmd_t               cmd_i,
  output sc_sts_t               sts_o,
  output sc_out_t               out_data_o
);

  localparam int ACC_W = SAMPLE_BITS + MAX_LEVEL;
  localparam int CNT_W = MAX_LEVEL + 1;
  localparam int LVL_W = $clog2(MAX_LEVEL + 1);

  logic [MODE_W-1:0]             mode_q;
  logic [LEVEL_W-1:0]            level_q;
  logic signed [ACC_W-1:0]       sum_l_q, sum_r_q;
  logic [CNT_W-1:0]              count_q;
  logic [CNT_W-1:0]              rem_q;
  logic signed [SAMPLE_BITS-1:0] smp_l_q, smp_r_q;
  logic                          eoc_q;
  logic signed [ACC_W-1:0]       prod_l_q, prod_r_q;
  logic                          neg_l_q, neg_r_q;
  logic signed [SAMPLE_BITS-1:0] res_l_q, res_r_q;

  logic [LVL_W-1:0]        lvl;
  logic [CNT_W-1:0]        win_len;
  logic [CNT_W-1:0]        steps;
  logic                    quant;
  logic                    load;
  logic [ACC_W-1:0]        dvd_l, dvd_r;
  logic [CNT_W-1:0]        dvs;
  logic [ACC_W-1:0]        quot_l, quot_r;
  logic                    done_l, done_r;
  logic [ACC_W-1:0]        sres_l, sres_r;

  function automatic logic [ACC_W-1:0] mag(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  // drop the fraction of the scaled sample, keep it scaled by full range
  function automatic logic [ACC_W-1:0] qmag(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = mag(v);
    return {m[ACC_W-1:FRAC_BITS], FRAC_BITS'(0)};
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sgn(
    input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, {FRAC_BITS{1'b1}}};
  endfunction

  assign lvl     = (level_q > LEVEL_W'(MAX_LEVEL)) ? LVL_W'(MAX_LEVEL) : LVL_W'(level_q);
  assign win_len = CNT_W'(1) << lvl;
  assign steps   = win_len - 1'b1;
  assign quant   = (mode_q == MODE_QUANT);
  assign load    = cmd_i.start_div || cmd_i.load_sign || cmd_i.load_zero;

  assign dvd_l = quant ? qmag(prod_l_q) : mag(sum_l_q);
  assign dvd_r = quant ? qmag(prod_r_q) : mag(sum_r_q);
  assign dvs   = quant ? steps : count_q;

  assign sres_l = neg_l_q ? ACC_W'(-quot_l) : quot_l;
  assign sres_r = neg_r_q ? ACC_W'(-quot_r) : quot_r;

  sc_div #(.DVD_W(ACC_W), .DVS_W(CNT_W)) u_div_l (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.start_div),
    .dividend_i(dvd_l),
    .divisor_i (dvs),
    .quot_o    (quot_l),
    .done_o    (done_l)
  );

  sc_div #(.DVD_W(ACC_W), .DVS_W(CNT_W)) u_div_r (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.start_div),
    .dividend_i(dvd_r),
    .divisor_i (dvs),
    .quot_o    (quot_r),
    .done_o    (done_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_AVG;
      level_q <= '0;
      sum_l_q <= '0;
      sum_r_q <= '0;
      count_q <= '0;
      rem_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MODE:  mode_q  <= cfg_wdata_i[MODE_W-1:0];
          REG_LEVEL: level_q <= cfg_wdata_i[LEVEL_W-1:0];
          default:   ;
        endcase
      end
      if (cmd_i.acc) begin
        if (quant) begin
          sum_l_q <= '0;
          sum_r_q <= '0;
          count_q <= '0;
        end else begin
          sum_l_q <= sum_l_q + ACC_W'(smp_l_q);
          sum_r_q <= sum_r_q + ACC_W'(smp_r_q);
          count_q <= count_q + 1'b1;
        end
      end else if (load) begin
        // close the window and owe one word per pair in it, or one in quantize mode
        rem_q   <= quant ? CNT_W'(1) : count_q;
        sum_l_q <= '0;
        sum_r_q <= '0;
        count_q <= '0;
      end else if (cmd_i.pop) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      smp_l_q <= in_data_i.left_sample;
      smp_r_q <= in_data_i.right_sample;
      eoc_q   <= in_data_i.end_of_call;
    end
    if (cmd_i.acc) begin
      prod_l_q <= ACC_W'(smp_l_q) * signed'(ACC_W'(steps));
      prod_r_q <= ACC_W'(smp_r_q) * signed'(ACC_W'(steps));
    end
    if (cmd_i.start_div) begin
      neg_l_q <= quant ? prod_l_q[ACC_W-1] : sum_l_q[ACC_W-1];
      neg_r_q <= quant ? prod_r_q[ACC_W-1] : sum_r_q[ACC_W-1];
    end
    if (cmd_i.load_sign) begin
      res_l_q <= sgn(sum_l_q);
      res_r_q <= sgn(sum_r_q);
    end else if (cmd_i.load_zero) begin
      res_l_q <= '0;
      res_r_q <= '0;
    end else if (cmd_i.take_div) begin
      res_l_q <= sres_l[SAMPLE_BITS-1:0];
      res_r_q <= sres_r[SAMPLE_BITS-1:0];
    end
  end

  assign sts_o.quant     = quant;
  assign sts_o.sign_mode = (mode_q != MODE_AVG) && (mode_q != MODE_QUANT);
  assign sts_o.close     = (count_q >= win_len) || eoc_q;
  assign sts_o.lvl_zero  = (lvl == '0);
  assign sts_o.div_done  = done_l && done_r;
  assign sts_o.last      = (rem_q == CNT_W'(1));

  assign out_data_o.left_out    = res_l_q;
  assign out_data_o.right_out   = res_r_q;
  assign out_data_o.last_of_run = sts_o.last;

  a_pop_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> rem_q != '0)
    else $error("result word taken with none owed");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc && !quant |=> count_q != '0)
    else $error("window count failed to advance");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the stereo crush effect
// Walks a directed table of register writes and sample words, then random
// phases of mode and level. A local model of the crusher predicts every
// result word, and each word taken from the block is checked against it.
// ----------------------------------------------------------------------------
module testbench;
  import sc_pkg::*;

  localparam int FULL_SCALE    = 1 << FRAC_BITS;
  localparam int RAND_WORDS    = 250;
  localparam int CALM_WORDS    = 40;   // tail of the run with no idling
  localparam int SETTLE_CYCLES = 32;   // covers the divider latency
  localparam int HOLD_CYCLES   = 300;  // long receiver stall, applied once
  localparam int HOLD_AFTER    = 40;   // result words before the long stall
  localparam int STALL_LIMIT   = 4000; // cycles without any handshake
  localparam int MAX_REPORTS   = 10;

  // spare mode code, behaves as the sign mode
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // one row of the directed table: a register write or a sample word
  typedef struct packed {
    logic                          is_reg;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_DATA_W-1:0]         val;
    sc_in_t                        word;
    logic                          typed;  // expected pair given in the row
    logic signed [SAMPLE_BITS-1:0] exp_l;
    logic signed [SAMPLE_BITS-1:0] exp_r;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sc_in_t                in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sc_out_t               out_data;

  // local copy of the crusher registers and window state
  logic [MODE_W-1:0]  mode_q  = MODE_AVG;
  logic [LEVEL_W-1:0] level_q = '0;
  longint             left_acc;
  longint             right_acc;
  int                 pairs_in_window;

  sc_out_t crushed_q[$];  // result words still owed by the block

  int mismatches = 0;
  int words_seen = 0;
  bit calm       = 1'b0;
  bit hold_done  = 1'b0;
  int tx_gap_pct = 30;
  int rx_gap_pct = 30;

  stereo_crush_effect uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Truncate toward zero onto 2^lvl-1 steps, then scale back to full range.
  function automatic longint requantize(longint s, int lvl);
    longint steps;
    longint q;
    steps = (longint'(1) << lvl) - 1;
    if (steps <= 0) return 0;
    q = (s * steps) / FULL_SCALE;
    return (q * FULL_SCALE) / steps;
  endfunction

  // Negative sum gives -1, anything else saturated +1.
  function automatic longint sign_clip(longint sum);
    return (sum < 0) ? -FULL_SCALE : FULL_SCALE - 1;
  endfunction

  // Bias toward the extremes so that saturation and sign edges come up often.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic stim_row_t word_row(int l, int rs, logic eoc, logic typed,
                                         int el, int er);
    stim_row_t r;
    r                   = '0;
    r.word.left_sample  = SAMPLE_BITS'(l);
    r.word.right_sample = SAMPLE_BITS'(rs);
    r.word.end_of_call  = eoc;
    r.typed             = typed;
    r.exp_l             = SAMPLE_BITS'(el);
    r.exp_r             = SAMPLE_BITS'(er);
    return r;
  endfunction

  // Advance the local crusher by one accepted pair and queue the words it owes.
  // A typed row replaces the computed pair, but count and last flag still
  // follow the window state.
  task automatic crush_pair(sc_in_t w, logic typed,
                            logic signed [SAMPLE_BITS-1:0] el,
                            logic signed [SAMPLE_BITS-1:0] er);
    longint  sl;
    longint  sr;
    longint  ol;
    longint  orr;
    int      lvl;
    int      n;
    sc_out_t r;
    lvl = (level_q > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(level_q);
    sl  = $signed(w.left_sample);
    sr  = $signed(w.right_sample);
    if (mode_q == MODE_QUANT) begin
      // quantize drops any partial window
      left_acc        = 0;
      right_acc       = 0;
      pairs_in_window = 0;
      ol              = requantize(sl, lvl);
      orr             = requantize(sr, lvl);
      n               = 1;
    end else begin
      left_acc        += sl;
      right_acc       += sr;
      pairs_in_window += 1;
      if (pairs_in_window < (1 << lvl) && !w.end_of_call) return;
      n = pairs_in_window;
      if (mode_q == MODE_AVG) begin
        ol  = left_acc / n;
        orr = right_acc / n;
      end else begin
        ol  = sign_clip(left_acc);
        orr = sign_clip(right_acc);
      end
      left_acc        = 0;
      right_acc       = 0;
      pairs_in_window = 0;
    end
    if (typed) begin
      ol  = el;
      orr = er;
    end
    for (int k = 0; k < n; k++) begin
      r.left_out    = SAMPLE_BITS'(ol);
      r.right_out   = SAMPLE_BITS'(orr);
      r.last_of_run = (k == n - 1);
      crushed_q.push_back(r);
    end
  endtask

  // Offer one word, after an optional idle burst, and hold it until taken.
  // Valid is left high on return so that a following word goes out back to back.
  task automatic send_word(sc_in_t w, logic typed,
                           logic signed [SAMPLE_BITS-1:0] el,
                           logic signed [SAMPLE_BITS-1:0] er);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    crush_pair(w, typed, el, er);
  endtask

  // Drain every owed word, let the block settle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (crushed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODE) mode_q = val[MODE_W-1:0];
    else level_q = val;
  endtask

  // Stimulus: directed table first, then random phases.
  initial begin
    stim_row_t rows[$];
    sc_in_t    w;
    int        sent;
    int        phase_len;
    int        pick;

    left_acc        = 0;
    right_acc       = 0;
    pairs_in_window = 0;

    // reset state: mode average, level zero, each pair comes back as is
    rows.push_back(word_row(32767, -32768, 1'b0, 1'b1, 32767, -32768));
    rows.push_back(word_row(0, 0, 1'b1, 1'b1, 0, 0));
    rows.push_back(word_row(-1, 1, 1'b0, 1'b1, -1, 1));
    // full window of four at both extremes
    rows.push_back(reg_row(REG_LEVEL, 3'd2));
    rows.push_back(word_row(32767, -32768, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(32767, -32768, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(32767, -32768, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(32767, -32768, 1'b0, 1'b1, 32767, -32768));
    // partial window closed by end of call, divided by its true count
    rows.push_back(word_row(100, -100, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(-3, 5, 1'b1, 1'b0, 0, 0));
    // sign mode: zero sum clips high, small sums give both signs
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_SIGN}));
    rows.push_back(word_row(0, 0, 1'b1, 1'b1, 32767, 32767));
    rows.push_back(word_row(-5, 5, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(4, -4, 1'b1, 1'b1, -32768, 32767));
    // quantize at level zero gives silence
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_QUANT}));
    rows.push_back(reg_row(REG_LEVEL, 3'd0));
    rows.push_back(word_row(12345, -32768, 1'b0, 1'b1, 0, 0));
    // level above the maximum saturates
    rows.push_back(reg_row(REG_LEVEL, 3'd7));
    rows.push_back(word_row(32767, -32768, 1'b1, 1'b0, 0, 0));
    rows.push_back(word_row(-1, 1, 1'b0, 1'b0, 0, 0));
    // one step: only full negative scale survives
    rows.push_back(reg_row(REG_LEVEL, 3'd1));
    rows.push_back(word_row(-32768, 32767, 1'b0, 1'b1, -32768, 0));
    // spare mode code acts as sign mode
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_SPARE}));
    rows.push_back(word_row(-1, -1, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(0, 0, 1'b0, 1'b1, -32768, -32768));
    // level lowered mid window: the next pair closes it
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_AVG}));
    rows.push_back(reg_row(REG_LEVEL, 3'd3));
    rows.push_back(word_row(10, 10, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(20, 20, 1'b0, 1'b0, 0, 0));
    rows.push_back(word_row(30, 30, 1'b0, 1'b0, 0, 0));
    rows.push_back(reg_row(REG_LEVEL, 3'd1));
    rows.push_back(word_row(40, 40, 1'b0, 1'b0, 0, 0));
    // switch to quantize mid window drops the partial window
    rows.push_back(reg_row(REG_LEVEL, 3'd2));
    rows.push_back(word_row(1000, 1000, 1'b0, 1'b0, 0, 0));
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_QUANT}));
    rows.push_back(word_row(16384, -16384, 1'b1, 1'b0, 0, 0));
    rows.push_back(reg_row(REG_MODE, {1'b0, MODE_AVG}));
    rows.push_back(word_row(7, -7, 1'b1, 1'b1, 7, -7));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_reg) write_reg(rows[i].idx, rows[i].val);
      else send_word(rows[i].word, rows[i].typed, rows[i].exp_l, rows[i].exp_r);
    end

    // Random phases: new mode and level, then a run of pairs. Windows carry
    // over between phases, so level and mode changes land mid window too.
    sent = 0;
    while (sent < RAND_WORDS) begin
      write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 7)));
      pick = $urandom_range(0, 9);
      if (pick < 7) write_reg(REG_LEVEL, CFG_DATA_W'($urandom_range(0, 3)));
      else if (pick < 9) write_reg(REG_LEVEL, CFG_DATA_W'($urandom_range(4, 5)));
      else write_reg(REG_LEVEL, CFG_DATA_W'($urandom_range(6, 7)));
      case ($urandom_range(0, 2))
        0:       tx_gap_pct = 0;
        1:       tx_gap_pct = 25;
        default: tx_gap_pct = 60;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_gap_pct = 0;
        1:       rx_gap_pct = 25;
        default: rx_gap_pct = 60;
      endcase
      phase_len = $urandom_range(4, 30);
      for (int i = 0; i < phase_len && sent < RAND_WORDS; i++) begin
        if (sent >= RAND_WORDS - CALM_WORDS) calm = 1'b1;
        w.left_sample  = pick_sample();
        w.right_sample = pick_sample();
        w.end_of_call  = ($urandom_range(0, 11) == 0);
        send_word(w, 1'b0, '0, '0);
        sent++;
      end
    end

    // drop valid, wait out every owed word and the divider latency
    in_valid <= 1'b0;
    while (crushed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && crushed_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: check each taken word against the oldest owed word, then pick
  // ready for the next cycle. Once, stall for a long stretch while the sender
  // keeps offering, so the block fills and holds its input.
  initial begin
    int      burst;
    sc_out_t want;
    burst = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        words_seen++;
        if (crushed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result word: left %0d right %0d last %0b",
                     out_data.left_out, out_data.right_out, out_data.last_of_run);
        end else begin
          want = crushed_q.pop_front();
          if (out_data.left_out !== want.left_out ||
              out_data.right_out !== want.right_out ||
              out_data.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result word %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       words_seen, want.left_out, want.right_out, want.last_of_run,
                       out_data.left_out, out_data.right_out, out_data.last_of_run);
          end
        end
      end
      if (!hold_done && words_seen >= HOLD_AFTER && in_valid) begin
        hold_done = 1'b1;
        burst     = HOLD_CYCLES;
      end else if (burst == 0 && !calm && $urandom_range(0, 99) < rx_gap_pct) begin
        burst = $urandom_range(1, 16);
      end
      if (burst > 0) begin
        burst--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
src/sc_pkg.sv
src/sc_div.sv
src/sc_ctrl.sv
src/sc_dp.sv
src/stereo_crush_effect.sv
bench/testbench.sv
